@@ rtl/ipb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipb_pkg
// Shared types, register codes and defaults for the interframe pixel blend.
// ----------------------------------------------------------------------------
package ipb_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 240;
    localparam int PIXEL_BITS_DEF = 32;

    localparam int PIX_PORT_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int FW_W       = 9;
    localparam int FH_W       = 8;
    localparam int NUM_STORES = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLEND_MODE   = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2,
        REG_LOW_MASK     = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        MODE_SMART = 1'b0,
        MODE_BLUR  = 1'b1
    } blend_mode_t;

    typedef logic [1:0] store_idx_t;

    localparam store_idx_t STORE_A = 2'd0;
    localparam store_idx_t STORE_B = 2'd1;
    localparam store_idx_t STORE_C = 2'd2;

    localparam blend_mode_t     BLEND_MODE_RST   = MODE_SMART;
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 9'd240;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 8'd160;
    localparam logic [31:0]     LOW_MASK_RST     = 32'h0001_0101;

    typedef struct packed {
        logic        valid;
        blend_mode_t mode;
        store_idx_t  newest;
    } stage_ctl_t;

    // (i + k) mod 3 for i, k in 0..2
    function automatic store_idx_t store_step(store_idx_t i, store_idx_t k);
        logic [2:0] sum;
        sum = {1'b0, i} + {1'b0, k};
        if (sum >= 3'd3) begin
            sum = sum - 3'd3;
        end
        return sum[1:0];
    endfunction

endpackage

@@ rtl/interframe_pixel_blend_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interframe_pixel_blend_top
// Smart flicker blending / motion blur over three rotating frame stores.
// ----------------------------------------------------------------------------
// Pipeline: an accepted word passes the position stage, the store read/write
//   stage, the compare stage and the output register before it shows on m_valid.
// Throughput: one word per cycle while the skid word is empty; each word
//   reads the old value and writes the new one at the same address together.
// Reset: synchronous; afterwards s_ready stays low while all MAX_WIDTH*MAX_HEIGHT
//   addresses (61440 by default) of all three stores are swept to zero.
// ----------------------------------------------------------------------------
module interframe_pixel_blend_top #(
    parameter int MAX_WIDTH  = ipb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ipb_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = ipb_pkg::PIXEL_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ipb_pkg::PIX_PORT_W-1:0] s_pixel_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ipb_pkg::PIX_PORT_W-1:0] m_pixel_out,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ipb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ipb_pkg::CFG_DATA_W-1:0] cfg_data
);

    import ipb_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int POS_W = $clog2(DEPTH);

    logic                  en;
    stage_ctl_t            s1_ctl;
    logic [PIXEL_BITS-1:0] s1_color;
    logic [PIXEL_BITS-1:0] low_mask;
    logic [POS_W-1:0]      mem_rd_addr;
    logic [NUM_STORES-1:0] mem_wr_en;
    logic [POS_W-1:0]      mem_wr_addr;
    logic [PIXEL_BITS-1:0] mem_wr_data;
    logic [PIXEL_BITS-1:0] rd_data [NUM_STORES];
    logic                  d_valid;
    logic [PIX_PORT_W-1:0] d_pixel;

    ipb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel_in  (s_pixel_in),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .en          (en),
        .s1_ctl      (s1_ctl),
        .s1_color    (s1_color),
        .low_mask    (low_mask),
        .mem_rd_addr (mem_rd_addr),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    for (genvar k = 0; k < NUM_STORES; k++) begin : g_store
        ipb_store #(
            .DEPTH  (DEPTH),
            .DATA_W (PIXEL_BITS)
        ) u_store (
            .aclk    (aclk),
            .rd_en   (en),
            .rd_addr (mem_rd_addr),
            .rd_data (rd_data[k]),
            .wr_en   (mem_wr_en[k]),
            .wr_addr (mem_wr_addr),
            .wr_data (mem_wr_data)
        );
    end

    ipb_blend #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_blend (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .s1_ctl   (s1_ctl),
        .s1_color (s1_color),
        .rd_data  (rd_data),
        .low_mask (low_mask),
        .d_valid  (d_valid),
        .d_pixel  (d_pixel)
    );

    ipb_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .d_valid     (d_valid),
        .d_pixel     (d_pixel),
        .en          (en),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out)
    );

endmodule

@@ rtl/ipb_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipb_store
// One frame store: single write port, registered read-first read port.
// ----------------------------------------------------------------------------
module ipb_store #(
    parameter int DEPTH  = 61440,
    parameter int DATA_W = 32
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // read returns the word held before a same-cycle write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ipb_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipb_front
// Config registers, pixel position and store rotation, store clear sweep,
// and the first pipeline stage that drives the frame store ports.
// ----------------------------------------------------------------------------
module ipb_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 240,
    parameter int PIXEL_BITS = 32
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic [ipb_pkg::PIX_PORT_W-1:0]            s_pixel_in,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [ipb_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [ipb_pkg::CFG_DATA_W-1:0]            cfg_data,
    input  logic                                      en,
    output ipb_pkg::stage_ctl_t                       s1_ctl,
    output logic [PIXEL_BITS-1:0]                     s1_color,
    output logic [PIXEL_BITS-1:0]                     low_mask,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]   mem_rd_addr,
    output logic [ipb_pkg::NUM_STORES-1:0]            mem_wr_en,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]   mem_wr_addr,
    output logic [PIXEL_BITS-1:0]                     mem_wr_data
);

    import ipb_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int POS_W = $clog2(DEPTH);
    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int H_W   = $clog2(MAX_HEIGHT + 1);
    localparam int SZ_W  = W_W + H_W;

    blend_mode_t     mode_reg;
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    logic [31:0]     mask_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    store_idx_t       rot_reg, rot_next;
    logic             clearing_reg;
    logic [POS_W-1:0] clr_cnt_reg;

    stage_ctl_t       s1_ctl_reg;
    logic [PIXEL_BITS-1:0] s1_color_reg;
    logic [POS_W-1:0] s1_addr_reg;
    store_idx_t       s1_target_reg;

    logic [W_W-1:0]   width_clamp;
    logic [H_W-1:0]   height_clamp;
    logic [SZ_W-1:0]  frame_size;
    logic [POS_W:0]   pos_inc;
    logic             frame_end;
    logic             accept;
    store_idx_t       target;

    // config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= BLEND_MODE_RST;
            width_reg  <= FRAME_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
            mask_reg   <= LOW_MASK_RST;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_BLEND_MODE:   mode_reg   <= blend_mode_t'(cfg_data[0]);
                REG_FRAME_WIDTH:  width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data[FH_W-1:0];
                REG_LOW_MASK:     mask_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign low_mask  = mask_reg[PIXEL_BITS-1:0];

    // frame size and position
    always_comb begin
        if (width_reg == '0) begin
            width_clamp = W_W'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            width_clamp = W_W'(MAX_WIDTH);
        end else begin
            width_clamp = W_W'(width_reg);
        end
        if (height_reg == '0) begin
            height_clamp = H_W'(1);
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            height_clamp = H_W'(MAX_HEIGHT);
        end else begin
            height_clamp = H_W'(height_reg);
        end
        frame_size = SZ_W'(width_clamp) * SZ_W'(height_clamp);
        pos_inc    = {1'b0, pos_reg} + 1'b1;
        frame_end  = 32'(pos_inc) >= 32'(frame_size);
        accept     = s_valid & s_ready;
        target     = (mode_reg == MODE_SMART) ? store_step(rot_reg, STORE_C) : rot_reg;

        pos_next = pos_reg;
        rot_next = rot_reg;
        if (accept) begin
            if (frame_end) begin
                pos_next = '0;
                if (mode_reg == MODE_SMART) begin
                    rot_next = store_step(rot_reg, STORE_C);
                end
            end else begin
                pos_next = pos_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            rot_reg      <= STORE_A;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else begin
            pos_reg <= pos_next;
            rot_reg <= rot_next;
            if (clearing_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (32'(clr_cnt_reg) == 32'(DEPTH - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    assign s_ready = en & ~clearing_reg;

    // stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
        end else if (en) begin
            s1_ctl_reg.valid <= accept;
            if (accept) begin
                s1_ctl_reg.mode   <= mode_reg;
                s1_ctl_reg.newest <= rot_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && accept) begin
            s1_color_reg  <= s_pixel_in[PIXEL_BITS-1:0];
            s1_addr_reg   <= pos_reg;
            s1_target_reg <= target;
        end
    end

    assign s1_ctl   = s1_ctl_reg;
    assign s1_color = s1_color_reg;

    // store ports
    always_comb begin
        for (int k = 0; k < NUM_STORES; k++) begin
            mem_wr_en[k] = clearing_reg |
                           (en & s1_ctl_reg.valid & (s1_target_reg == store_idx_t'(k)));
        end
    end

    assign mem_rd_addr = s1_addr_reg;
    assign mem_wr_addr = clearing_reg ? clr_cnt_reg : s1_addr_reg;
    assign mem_wr_data = clearing_reg ? '0 : s1_color_reg;

endmodule

@@ rtl/ipb_blend.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipb_blend
// Stages 2 and 3: aligns the pixel with store read data, detects flicker,
// and forms the per-channel average.
// ----------------------------------------------------------------------------
module ipb_blend #(
    parameter int PIXEL_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  ipb_pkg::stage_ctl_t            s1_ctl,
    input  logic [PIXEL_BITS-1:0]          s1_color,
    input  logic [PIXEL_BITS-1:0]          rd_data [ipb_pkg::NUM_STORES],
    input  logic [PIXEL_BITS-1:0]          low_mask,
    output logic                           d_valid,
    output logic [ipb_pkg::PIX_PORT_W-1:0] d_pixel
);

    import ipb_pkg::*;

    stage_ctl_t            s2_ctl_reg;
    logic [PIXEL_BITS-1:0] s2_color_reg;

    logic                  s3_valid_reg;
    logic                  s3_blend_reg;
    logic [PIXEL_BITS-1:0] s3_color_reg;
    logic [PIXEL_BITS-1:0] s3_half_a_reg;
    logic [PIXEL_BITS-1:0] s3_half_b_reg;

    logic [PIXEL_BITS-1:0] p_new, p_mid, p_old, keep;
    logic                  blend_next;
    logic [PIXEL_BITS-1:0] sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_ctl_reg   <= '0;
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s2_ctl_reg   <= s1_ctl;
            s3_valid_reg <= s2_ctl_reg.valid;
        end
    end

    always_comb begin
        case (s2_ctl_reg.newest)
            STORE_B: begin
                p_new = rd_data[STORE_B];
                p_mid = rd_data[STORE_C];
                p_old = rd_data[STORE_A];
            end
            STORE_C: begin
                p_new = rd_data[STORE_C];
                p_mid = rd_data[STORE_A];
                p_old = rd_data[STORE_B];
            end
            default: begin
                p_new = rd_data[STORE_A];
                p_mid = rd_data[STORE_B];
                p_old = rd_data[STORE_C];
            end
        endcase
        keep = ~low_mask;
        if (s2_ctl_reg.mode == MODE_SMART) begin
            blend_next = (p_new != p_mid) && (p_old != s2_color_reg) &&
                         ((s2_color_reg == p_mid) || (p_new == p_old));
        end else begin
            blend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_color_reg  <= s1_color;
            s3_blend_reg  <= blend_next;
            s3_color_reg  <= s2_color_reg;
            s3_half_a_reg <= (s2_color_reg & keep) >> 1;
            s3_half_b_reg <= (p_new & keep) >> 1;
        end
    end

    assign sum     = s3_half_a_reg + s3_half_b_reg;
    assign d_valid = s3_valid_reg;
    assign d_pixel = PIX_PORT_W'(s3_blend_reg ? sum : s3_color_reg);

endmodule

@@ rtl/ipb_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipb_out
// Output register with a skid word; holds the pipeline while the skid is full.
// ----------------------------------------------------------------------------
module ipb_out (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           d_valid,
    input  logic [ipb_pkg::PIX_PORT_W-1:0] d_pixel,
    output logic                           en,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ipb_pkg::PIX_PORT_W-1:0] m_pixel_out
);

    import ipb_pkg::*;

    logic                  out_valid_reg, out_valid_next;
    logic [PIX_PORT_W-1:0] out_data_reg, out_data_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic [PIX_PORT_W-1:0] skid_data_reg, skid_data_next;
    logic                  take;

    assign en = ~skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        take            = en & d_valid;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = take;
                out_data_next  = d_pixel;
            end
        end else if (take) begin
            skid_valid_next = 1'b1;
            skid_data_next  = d_pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_pixel_out = out_data_reg;

endmodule

@@ rtl/ipb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipb_checker
// Port-level checks for the interframe pixel blend, bound to the top level.
// ----------------------------------------------------------------------------
module ipb_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [ipb_pkg::PIX_PORT_W-1:0] m_pixel_out
);

    // stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_out))
        else $error("result word changed or dropped while stalled");

    // no result word right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    // input held off by reset
    assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("s_ready set during reset");

    // store clear sweep keeps input closed after reset release
    assert property (@(posedge aclk) $rose(aresetn) |=> !s_ready)
        else $error("s_ready set before store clear finished");

endmodule

bind interframe_pixel_blend_top ipb_checker u_ipb_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_pixel_out (m_pixel_out)
);
